FILE: design/hcsg_pkg.sv
// Shared constants for the Hilbert curve segment generator.
package hcsg_pkg;

    // Input beat: segment index, padded to whole bytes
    localparam int IDX_W       = 20;
    localparam int IN_TDATA_W  = 24;

    // Output beat: four canvas coordinates
    localparam int CRD_W       = 10;
    localparam int N_LANES     = 4;
    localparam int OUT_TDATA_W = N_LANES * CRD_W;

    // Coordinate lanes, lowest tdata bits first
    localparam int LN_SX = 0;
    localparam int LN_SY = 1;
    localparam int LN_EX = 2;
    localparam int LN_EY = 3;

    // Curve order register
    localparam int              CFG_W     = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd1;

    // Defaults for the top-level parameters
    localparam int MAX_ORDER_DEF  = 10;
    localparam int CANVAS_MAX_DEF = 1023;

    // Depth of the queue between front and back
    localparam int Q_DEPTH = 4;

endpackage

FILE: design/hcsg_front.sv
// Front end: order register, index range check and queue entry build.
module hcsg_front import hcsg_pkg::*; #(
    parameter int  MAX_ORDER = MAX_ORDER_DEF,
    localparam int OW        = $clog2(MAX_ORDER + 1),
    localparam int TW        = 2 * MAX_ORDER,
    localparam int ENT_W     = OW + 1 + 2 * TW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_TDATA_W-1:0] i_s_tdata,   // [19:0] segment_index
    input  logic                  i_full,
    output logic                  o_push,
    output logic [ENT_W-1:0]      o_ent
);

    logic [CFG_W-1:0] r_curve_order;
    logic [OW-1:0]    order;
    logic [IDX_W-1:0] k;
    logic [IDX_W:0]   k_inc;
    logic [OW:0]      shamt;
    logic             oor;
    logic [TW-1:0]    t0;
    logic [TW-1:0]    t1;

    // Hold the curve order register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_order <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_curve_order <= i_cfg_wdata;
        end
    end

    // Saturate the order into its legal range
    always_comb begin
        priority if (r_curve_order == '0) begin
            order = OW'(1);
        end else if (32'(r_curve_order) > MAX_ORDER) begin
            order = OW'(MAX_ORDER);
        end else begin
            order = OW'(r_curve_order);
        end
    end

    // Flag indices at or past the last point: k + 1 >= 4^order
    assign k     = i_s_tdata[IDX_W-1:0];
    assign k_inc = {1'b0, k} + (IDX_W + 1)'(1);
    assign shamt = {order, 1'b0};
    assign oor   = (k_inc >> shamt) != '0;

    // Curve indices of both segment ends
    assign t0 = TW'(k);
    assign t1 = t0 + TW'(1);

    // Push a beat whenever the queue has room
    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;
    assign o_ent      = {order, oor, t1, t0};

endmodule

FILE: design/hcsg_fifo.sv
// Short show-ahead queue between front and back.
module hcsg_fifo import hcsg_pkg::*; #(
    parameter int  DW    = 8,
    parameter int  DEPTH = Q_DEPTH,
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNW   = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_empty
);

    logic [DW-1:0]  r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CNW-1:0] r_count;

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (32'(r_wr) == DEPTH - 1) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (32'(r_rd) == DEPTH - 1) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNW'(1);
            end
        end
    end

    assign o_full  = (32'(r_count) == DEPTH);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (32'(r_count) < DEPTH))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= DEPTH)
        else $error("queue occupancy past depth");

endmodule

FILE: design/hcsg_back.sv
// Back end: per-level curve pipeline, canvas scaling and output register.
module hcsg_back import hcsg_pkg::*; #(
    parameter int  MAX_ORDER  = MAX_ORDER_DEF,
    parameter int  CANVAS_MAX = CANVAS_MAX_DEF,
    localparam int OW         = $clog2(MAX_ORDER + 1),
    localparam int TW         = 2 * MAX_ORDER,
    localparam int ENT_W      = OW + 1 + 2 * TW
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [ENT_W-1:0]       i_ent,
    input  logic                   i_empty,
    output logic                   o_pop,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,  // [9:0] start_x, [19:10] start_y,
                                               // [29:20] end_x, [39:30] end_y
    output logic                   o_m_tuser   // out_of_range
);

    localparam int MO = MAX_ORDER;
    localparam int CW = $clog2(CANVAS_MAX + 1);
    localparam int NW = MO + CW + 2;
    localparam int DW = MO + 1;

    typedef struct packed {
        logic          oor;
        logic [OW-1:0] ord;
        logic [TW-1:0] t0;
        logic [TW-1:0] t1;
        logic [MO-1:0] x0;
        logic [MO-1:0] y0;
        logic [MO-1:0] x1;
        logic [MO-1:0] y1;
    } t_cv;

    typedef struct packed {
        logic                         oor;
        logic [DW-1:0]                d;
        logic [N_LANES-1:0][NW-1:0]   r;
        logic [N_LANES-1:0][CW-1:0]   q;
    } t_dv;

    // One Hilbert level: fold the point into quadrant j of the index
    function automatic logic [2*MO-1:0] f_step(input logic [TW-1:0] t,
                                               input logic [MO-1:0] x,
                                               input logic [MO-1:0] y,
                                               input int j);
        logic          rx;
        logic          ry;
        logic [MO-1:0] xa;
        logic [MO-1:0] ya;
        logic [MO-1:0] tmp;
        logic [MO-1:0] mask;
        logic [MO-1:0] bitj;
        begin
            mask = MO'((32'd1 << j) - 32'd1);
            bitj = MO'(32'd1 << j);
            rx   = t[2*j+1];
            ry   = t[2*j] ^ rx;
            xa   = x;
            ya   = y;
            if (!ry) begin
                if (rx) begin
                    xa = xa ^ mask;
                    ya = ya ^ mask;
                end
                tmp = xa;
                xa  = ya;
                ya  = tmp;
            end
            if (rx) xa = xa | bitj;
            if (ry) ya = ya | bitj;
            return {xa, ya};
        end
    endfunction

    logic          en;
    logic          r_cv_vld [MO];
    t_cv           r_cv     [MO];
    logic          r_nm_vld;
    t_dv           r_nm;
    logic          r_dv_vld [CW];
    t_dv           r_dv     [CW];
    logic          r_out_vld;
    logic          r_out_oor;
    logic [CRD_W-1:0] r_out_crd [N_LANES];
    t_cv           head;
    t_cv           last;
    t_dv           fin;
    logic [MO-1:0] g;
    logic [MO-1:0] v [N_LANES];

    // Advance the whole pipe unless a finished beat waits downstream
    assign en    = !r_out_vld || i_m_tready;
    assign o_pop = en && !i_empty;

    // Unpack the queue head; both points start at the origin
    always_comb begin
        head     = '0;
        head.t0  = i_ent[TW-1:0];
        head.t1  = i_ent[2*TW-1:TW];
        head.oor = i_ent[2*TW];
        head.ord = i_ent[2*TW+OW:2*TW+1];
    end

    // Curve levels, one stage each, lowest index digit first
    for (genvar j = 0; j < MO; j++) begin : g_cv
        t_cv  src;
        logic src_vld;
        t_cv  nxt;

        if (j == 0) begin : g_first
            assign src     = head;
            assign src_vld = !i_empty;
        end else begin : g_next
            assign src     = r_cv[j-1];
            assign src_vld = r_cv_vld[j-1];
        end

        // Apply the level only below the item's order
        always_comb begin
            nxt = src;
            if (32'(src.ord) > j) begin
                {nxt.x0, nxt.y0} = f_step(src.t0, src.x0, src.y0, j);
                {nxt.x1, nxt.y1} = f_step(src.t1, src.x1, src.y1, j);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv_vld[j] <= 1'b0;
            end else if (en) begin
                r_cv_vld[j] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cv[j] <= nxt;
            end
        end
    end

    // Scale numerators 2*v*C + G and divisor 2*G
    assign last   = r_cv[MO-1];
    assign g      = MO'(((MO + 1)'(1) << last.ord) - (MO + 1)'(1));
    assign v[LN_SX] = last.x0;
    assign v[LN_SY] = last.y0;
    assign v[LN_EX] = last.x1;
    assign v[LN_EY] = last.y1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nm_vld <= 1'b0;
        end else if (en) begin
            r_nm_vld <= r_cv_vld[MO-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nm.oor <= last.oor;
            r_nm.d   <= {g, 1'b0};
            for (int c = 0; c < N_LANES; c++) begin
                r_nm.r[c] <= NW'({v[c], 1'b0}) * NW'(CANVAS_MAX) + NW'(g);
                r_nm.q[c] <= '0;
            end
        end
    end

    // Restoring division, one quotient bit per stage, MSB first
    for (genvar m = 0; m < CW; m++) begin : g_dv
        localparam int B = CW - 1 - m;
        t_dv  src;
        logic src_vld;
        t_dv  nxt;

        if (m == 0) begin : g_first
            assign src     = r_nm;
            assign src_vld = r_nm_vld;
        end else begin : g_next
            assign src     = r_dv[m-1];
            assign src_vld = r_dv_vld[m-1];
        end

        always_comb begin
            logic [NW-1:0] sub;
            logic          ge;
            nxt = src;
            sub = NW'(src.d) << B;
            for (int c = 0; c < N_LANES; c++) begin
                ge = src.r[c] >= sub;
                if (ge) begin
                    nxt.r[c] = src.r[c] - sub;
                end
                nxt.q[c] = src.q[c] | (CW'(ge) << B);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[m] <= 1'b0;
            end else if (en) begin
                r_dv_vld[m] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[m] <= nxt;
            end
        end
    end

    // Output register: zero coordinates past the curve
    assign fin = r_dv[CW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_dv_vld[CW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_oor <= fin.oor;
            for (int c = 0; c < N_LANES; c++) begin
                r_out_crd[c] <= fin.oor ? '0 : CRD_W'(fin.q[c]);
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_out_oor;
    assign o_m_tdata  = {r_out_crd[LN_EY], r_out_crd[LN_EX],
                         r_out_crd[LN_SY], r_out_crd[LN_SX]};

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("out-of-range beat with nonzero coordinates");

    a_canvas_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |->
            ((32'(o_m_tdata[CRD_W-1:0]) <= CANVAS_MAX) &&
             (32'(o_m_tdata[2*CRD_W-1:CRD_W]) <= CANVAS_MAX) &&
             (32'(o_m_tdata[3*CRD_W-1:2*CRD_W]) <= CANVAS_MAX) &&
             (32'(o_m_tdata[4*CRD_W-1:3*CRD_W]) <= CANVAS_MAX)))
        else $error("scaled coordinate past canvas edge");

endmodule

FILE: design/hilbert_curve_segment_generator.sv
// Hilbert curve segment generator: index in, scaled segment endpoints out.
// Throughput: one beat per cycle in and out; the back pipe stalls only on output backpressure.
// Path from input beat to output valid: the queue, then one stage per curve level, one scaling
//   multiply stage, one stage per quotient bit and the output register.
// Reset (synchronous, active low) empties the queue and pipe and sets curve order to 1.
// Orders outside 1..MAX_ORDER saturate to the nearest legal value.
module hilbert_curve_segment_generator import hcsg_pkg::*; #(
    parameter int MAX_ORDER  = MAX_ORDER_DEF,
    parameter int CANVAS_MAX = CANVAS_MAX_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_wdata,   // curve_order
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,     // [19:0] segment_index
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,     // [9:0] start_x, [19:10] start_y,
                                                  // [29:20] end_x, [39:30] end_y
    output logic                   o_m_tuser      // out_of_range
);

    localparam int OW    = $clog2(MAX_ORDER + 1);
    localparam int TW    = 2 * MAX_ORDER;
    localparam int ENT_W = OW + 1 + 2 * TW;

    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    logic [ENT_W-1:0] ent_in;
    logic [ENT_W-1:0] ent_out;

    hcsg_front #(
        .MAX_ORDER (MAX_ORDER)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_full      (full),
        .o_push      (push),
        .o_ent       (ent_in)
    );

    hcsg_fifo #(
        .DW    (ENT_W),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (ent_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (ent_out),
        .o_empty (empty)
    );

    hcsg_back #(
        .MAX_ORDER  (MAX_ORDER),
        .CANVAS_MAX (CANVAS_MAX)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ent      (ent_out),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

FILE: tb/hcsg_segment_checker.sv
// Checker for the Hilbert curve segment generator: predicts each segment and compares beats.
`timescale 1ns / 1ps

module hcsg_segment_checker import hcsg_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                   i_m_tuser,
    output int                     o_errors,
    output int                     o_pending
);

    typedef struct packed {
        logic [CRD_W-1:0] sx;
        logic [CRD_W-1:0] sy;
        logic [CRD_W-1:0] ex;
        logic [CRD_W-1:0] ey;
        logic             oor;
    } t_segment;

    logic [CFG_W-1:0] order_reg;
    t_segment         expected_segments[$];
    int               err_count;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        err_count = 0;
        order_reg = CFG_RESET;
    end

    // Walk the curve from the finest level up to the full grid
    function automatic void curve_point(input int unsigned ord, input int unsigned d,
                                        output int unsigned px, output int unsigned py);
        int unsigned x, y, t, s, rx, ry, tmp, n;
        x = 0;
        y = 0;
        t = d;
        n = 1 << ord;
        for (s = 1; s < n; s = s << 1) begin
            rx = 1 & (t >> 1);
            ry = 1 & (t ^ rx);
            if (ry == 0) begin
                if (rx == 1) begin
                    x = s - 1 - x;
                    y = s - 1 - y;
                end
                tmp = x;
                x   = y;
                y   = tmp;
            end
            x = x + s * rx;
            y = y + s * ry;
            t = t >> 2;
        end
        px = x;
        py = y;
    endfunction

    // Round v * CANVAS_MAX / g to nearest; g is odd so no tie arises
    function automatic logic [CRD_W-1:0] scale_coord(input int unsigned v, input int unsigned g);
        int unsigned q;
        q = (2 * v * CANVAS_MAX_DEF + g) / (2 * g);
        return q[CRD_W-1:0];
    endfunction

    function automatic t_segment predict_segment(input logic [CFG_W-1:0] cfg,
                                                 input logic [IDX_W-1:0] k);
        int unsigned ord, last, g, x0, y0, x1, y1;
        t_segment    seg;
        // Saturate the order into the legal range
        ord = cfg;
        if (ord < 1) ord = 1;
        if (ord > MAX_ORDER_DEF) ord = MAX_ORDER_DEF;
        last = (1 << (2 * ord)) - 1;
        g    = (1 << ord) - 1;
        seg  = '0;
        if (k >= last) begin
            seg.oor = 1'b1;
        end else begin
            curve_point(ord, k, x0, y0);
            curve_point(ord, k + 1, x1, y1);
            seg.sx = scale_coord(x0, g);
            seg.sy = scale_coord(y0, g);
            seg.ex = scale_coord(x1, g);
            seg.ey = scale_coord(y1, g);
        end
        return seg;
    endfunction

    always @(posedge i_clk) begin
        t_segment want;
        t_segment got;
        if (!i_rst_n) begin
            order_reg = CFG_RESET;
            expected_segments.delete();
        end else begin
            // Compare an output beat with the oldest expectation
            if (i_m_tvalid && i_m_tready) begin
                got.sx  = i_m_tdata[LN_SX*CRD_W +: CRD_W];
                got.sy  = i_m_tdata[LN_SY*CRD_W +: CRD_W];
                got.ex  = i_m_tdata[LN_EX*CRD_W +: CRD_W];
                got.ey  = i_m_tdata[LN_EY*CRD_W +: CRD_W];
                got.oor = i_m_tuser;
                if (expected_segments.size() == 0) begin
                    $error("unexpected output beat: tdata %h, tuser %b", i_m_tdata, i_m_tuser);
                    err_count++;
                end else begin
                    want = expected_segments.pop_front();
                    if (got.sx != want.sx) begin
                        $error("start_x mismatch: expected %0d, got %0d", want.sx, got.sx);
                        err_count++;
                    end
                    if (got.sy != want.sy) begin
                        $error("start_y mismatch: expected %0d, got %0d", want.sy, got.sy);
                        err_count++;
                    end
                    if (got.ex != want.ex) begin
                        $error("end_x mismatch: expected %0d, got %0d", want.ex, got.ex);
                        err_count++;
                    end
                    if (got.ey != want.ey) begin
                        $error("end_y mismatch: expected %0d, got %0d", want.ey, got.ey);
                        err_count++;
                    end
                    if (got.oor != want.oor) begin
                        $error("out_of_range mismatch: expected %0d, got %0d",
                               want.oor, got.oor);
                        err_count++;
                    end
                end
            end
            // Predict from the order in force before this edge
            if (i_s_tvalid && i_s_tready) begin
                expected_segments.insert(expected_segments.size(),
                    predict_segment(order_reg, i_s_tdata[IDX_W-1:0]));
            end
            if (i_cfg_we) begin
                order_reg = i_cfg_wdata;
            end
        end
        o_pending <= expected_segments.size();
        o_errors  <= err_count;
    end

endmodule

FILE: tb/hilbert_curve_segment_generator_tb.sv
// Testbench top for the Hilbert curve segment generator: stimulus, backpressure and verdict.
`timescale 1ns / 1ps

module hilbert_curve_segment_generator_tb;
    import hcsg_pkg::*;

    localparam int PIPE_LAT  = MAX_ORDER_DEF + $clog2(CANVAS_MAX_DEF + 1) + 2;
    localparam int N_PHASES  = 10;
    localparam int PHASE_LEN = 50;
    localparam int HOLD_LEN  = 300;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   cfg_we      = 1'b0;
    logic [CFG_W-1:0]       cfg_wdata   = '0;
    logic                   s_tvalid    = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata     = '0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   ready_want  = 1'b0;
    logic                   hold_off    = 1'b0;
    logic                   m_tready;
    logic [CFG_W-1:0]       cur_order   = CFG_RESET;
    bit                     burst_mode  = 1'b0;
    bit                     pressure_go = 1'b0;
    int                     errors;
    int                     pending;

    assign m_tready = ready_want & ~hold_off;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    hilbert_curve_segment_generator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

    hcsg_segment_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Offer one index beat after a random gap; return once it is taken
    task automatic send_index(input logic [IDX_W-1:0] idx);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tdata  <= {{(IN_TDATA_W-IDX_W){1'b0}}, idx};
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // Drain all segments, let the pipe settle, then write the order
    task automatic write_order(input logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        cur_order = value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Pick an index: mostly on the curve, some at its end, some anywhere
    function automatic logic [IDX_W-1:0] pick_index(input logic [CFG_W-1:0] cfg);
        int unsigned ord, last, r, v;
        ord = cfg;
        if (ord < 1) ord = 1;
        if (ord > MAX_ORDER_DEF) ord = MAX_ORDER_DEF;
        last = (1 << (2 * ord)) - 1;
        r    = $urandom_range(0, 99);
        if (r < 70) begin
            v = $urandom_range(0, last - 1);
        end else if (r < 85) begin
            v = last - 1 + $urandom_range(0, 2);
            if (v > 20'hFFFFF) v = 20'hFFFFF;
        end else begin
            v = $urandom();
        end
        return v[IDX_W-1:0];
    endfunction

    // Receiver: random stall before each beat
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = burst_mode ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                ready_want <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            ready_want <= 1'b1;
            @(posedge i_clk);
            while (!(m_tvalid && m_tready)) @(posedge i_clk);
        end
    end

    // Long receiver hold-off so the queue fills and input stalls
    initial begin
        wait (pressure_go);
        repeat (20) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [CFG_W-1:0] phase_order [N_PHASES];
        phase_order = '{4'd10, 4'd1, 4'd0, 4'd15, 4'd2, 4'd10, 4'd5, 4'd3, 4'd12, 4'd7};
        phase_order[6] = CFG_W'($urandom_range(1, 10));
        phase_order[9] = CFG_W'($urandom_range(0, 15));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset order 1, every segment and the ends past the curve
        send_index(20'd0);
        send_index(20'd1);
        send_index(20'd2);
        send_index(20'd3);
        send_index(20'hFFFFF);
        // Largest order: first and last segments, the boundary, bit patterns
        write_order(4'd10);
        send_index(20'd0);
        send_index(20'd1);
        send_index(20'd1048573);
        send_index(20'd1048574);
        send_index(20'hFFFFF);
        send_index(20'h55555);
        send_index(20'hAAAAA);
        // Order zero saturates up to one
        write_order(4'd0);
        send_index(20'd0);
        send_index(20'd2);
        send_index(20'd3);
        // Order above the maximum saturates down
        write_order(4'd15);
        send_index(20'd1048573);
        send_index(20'd1048574);
        send_index(20'd524287);
        // Order two around its end
        write_order(4'd2);
        send_index(20'd13);
        send_index(20'd14);
        send_index(20'd15);

        // Random phases, each under its own order
        for (int p = 0; p < N_PHASES; p++) begin
            write_order(phase_order[p]);
            burst_mode = (p == 0) || (p == 4);
            if (p == 0) pressure_go = 1'b1;
            for (int i = 0; i < PHASE_LEN; i++) begin
                send_index(pick_index(cur_order));
            end
            burst_mode = 1'b0;
        end
        s_tvalid <= 1'b0;

        // Wait out the last segments and any stray beats
        do @(posedge i_clk); while (pending != 0);
        repeat (2 * PIPE_LAT) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
